/* rtl/itbl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itbl_pkg;

    // Table depth used when the top level is not given another one.
    localparam int DEFAULT_CAPACITY = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LINEAR = 2'd2,
        OP_BINARY = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_DRAIN,
        ST_INS_PUT,
        ST_DEL_SHIFT,
        ST_DEL_DRAIN,
        ST_LIN,
        ST_BIN_RD,
        ST_BIN_CMP,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

/* rtl/indexed_table_insert_delete_search.sv */
`timescale 1ns / 1ps
`default_nettype none

// Ordered table of CAPACITY signed 32-bit entries in a single-port-write,
// single-port-read synchronous RAM, plus a count of valid entries. Each request
// item (insert at a position, delete at a position, linear search, binary
// search) yields one response item with a status, a found index and the new
// entry count. The block works on one request at a time; the RAM has one read
// and one write per cycle, and that port sets the timing. An insert shifts the
// entries from its position upward and a delete shifts those above it downward;
// every moved entry passes through the RAM once (reads and write-backs overlap).
// A delete of the last entry only lowers the count. Each binary search probe
// first puts out the address, then compares against the registered read data.
// A rejected request and a linear search of an empty table go straight to the
// finishing state. The response item shows up in the same cycle in which the
// block can first take the next request item. A new request item is taken only
// when the block is idle; the finished response sits in an output register, so
// the block goes idle even while the response item waits to be taken. No
// clearing pass is needed after reset: only entries below the count are ever used.
module indexed_table_insert_delete_search
    import itbl_pkg::*;
#(
    parameter int  CAPACITY = DEFAULT_CAPACITY,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    req_valid,
    output logic                         req_stall,
    input  wire logic [1:0]              opcode,
    input  wire logic [IDX_W-1:0]        position,
    input  wire logic signed [31:0]      value,

    output logic                         rsp_valid,
    input  wire logic                    rsp_stall,
    output logic [1:0]                   status,
    output logic [IDX_W-1:0]             found_index,
    output logic [CNT_W-1:0]             entry_count
);

    // Table RAM. Reset leaves it undefined; only written entries are used.
    logic [31:0]       table_mem [CAPACITY];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [31:0]       mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [31:0]       rdata_reg;

    state_t            state_reg, state_next;

    // Request held for the duration of the operation.
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Walk index and the write-back that follows each read in the next cycle.
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;

    // Binary search bounds; hi1 is one past the upper bound so it never goes negative.
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi1_reg, hi1_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;

    // Result waiting in the finishing state.
    status_t           res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_index_reg, res_index_next;

    // Output register.
    logic              rsp_valid_reg, rsp_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  found_index_reg, found_index_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;

    logic              req_take;
    logic              rsp_free;
    logic [CNT_W-1:0]  pos_ext_in;
    logic [CNT_W-1:0]  cnt_last;
    logic [CNT_W-1:0]  idx_ext;
    logic              table_full;
    logic              ins_range;
    logic              ins_append;
    logic              del_range;
    logic              del_last;
    logic              ins_at_pos;
    logic              walk_at_last;
    logic              chk_hit;
    logic              bin_empty;
    logic [CNT_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid_calc;
    logic              probe_less;

    assign req_stall   = (state_reg != ST_IDLE);
    assign req_take    = req_valid && !req_stall;
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;

    assign pos_ext_in  = CNT_W'(position);
    assign cnt_last    = cnt_reg - CNT_W'(1);
    assign idx_ext     = CNT_W'(idx_reg);
    assign table_full  = (cnt_reg == CNT_W'(CAPACITY));
    assign ins_range   = (pos_ext_in > cnt_reg);
    assign ins_append  = (pos_ext_in == cnt_reg);
    assign del_range   = (pos_ext_in >= cnt_reg);
    assign del_last    = (pos_ext_in == cnt_last);
    assign ins_at_pos  = (idx_reg == pos_reg);
    assign walk_at_last = (idx_ext == cnt_last);
    // In the linear walk, pend_reg marks that rdata_reg holds entry pend_addr_reg.
    assign chk_hit     = pend_reg && (rdata_reg == val_reg);
    assign bin_empty   = (lo_reg >= hi1_reg);
    assign mid_sum     = (CNT_W + 1)'(lo_reg) + (CNT_W + 1)'(hi1_reg) - (CNT_W + 1)'(1);
    assign mid_calc    = mid_sum[IDX_W:1];
    assign probe_less  = ($signed(rdata_reg) < val_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    case (opcode_t'(opcode))
                        OP_INSERT:
                        begin
                            if (table_full || ins_range)
                            begin
                                state_next = ST_FIN;
                            end
                            else if (ins_append)
                            begin
                                state_next = ST_INS_PUT;
                            end
                            else
                            begin
                                state_next = ST_INS_SHIFT;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (del_range || del_last)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_DEL_SHIFT;
                            end
                        end
                        OP_LINEAR:
                        begin
                            state_next = (cnt_reg == '0) ? ST_FIN : ST_LIN;
                        end
                        default:
                        begin
                            state_next = ST_BIN_RD;
                        end
                    endcase
                end
            end
            ST_INS_SHIFT:
            begin
                if (ins_at_pos)
                begin
                    state_next = ST_INS_DRAIN;
                end
            end
            ST_INS_DRAIN: state_next = ST_INS_PUT;
            ST_INS_PUT:   state_next = ST_FIN;
            ST_DEL_SHIFT:
            begin
                if (walk_at_last)
                begin
                    state_next = ST_DEL_DRAIN;
                end
            end
            ST_DEL_DRAIN: state_next = ST_FIN;
            ST_LIN:
            begin
                if (chk_hit || (pend_reg && (CNT_W'(pend_addr_reg) == cnt_last)))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_BIN_RD:
            begin
                state_next = bin_empty ? ST_FIN : ST_BIN_CMP;
            end
            ST_BIN_CMP:
            begin
                state_next = (rdata_reg == val_reg) ? ST_FIN : ST_BIN_RD;
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM controls and result.
    always_comb
    begin
        pos_next         = pos_reg;
        val_next         = val_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        lo_next          = lo_reg;
        hi1_next         = hi1_reg;
        mid_next         = mid_reg;
        res_status_next  = res_status_reg;
        res_index_next   = res_index_reg;
        rsp_valid_next   = rsp_valid_reg;
        status_next      = status_reg;
        found_index_next = found_index_reg;
        entry_count_next = entry_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = pend_addr_reg;
        mem_wdata        = rdata_reg;
        mem_raddr        = idx_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    pos_next        = position;
                    val_next        = value;
                    pend_next       = 1'b0;
                    res_status_next = STAT_OK;
                    res_index_next  = '0;
                    case (opcode_t'(opcode))
                        OP_INSERT:
                        begin
                            if (table_full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else if (ins_range)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            idx_next = cnt_last[IDX_W-1:0];
                        end
                        OP_DELETE:
                        begin
                            if (del_range)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else if (del_last)
                            begin
                                cnt_next = cnt_last;
                            end
                            idx_next = position + IDX_W'(1);
                        end
                        OP_LINEAR:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                            idx_next = '0;
                        end
                        default:
                        begin
                            lo_next  = '0;
                            hi1_next = cnt_reg;
                        end
                    endcase
                end
            end
            ST_INS_SHIFT:
            begin
                // Read entry idx while the previous read lands one place up.
                mem_we         = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = idx_reg + IDX_W'(1);
                idx_next       = idx_reg - IDX_W'(1);
            end
            ST_INS_DRAIN:
            begin
                mem_we = 1'b1;
            end
            ST_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = val_reg;
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            ST_DEL_SHIFT:
            begin
                // Read entry idx while the previous read lands one place down.
                mem_we         = pend_reg;
                pend_next      = 1'b1;
                pend_addr_next = idx_reg - IDX_W'(1);
                idx_next       = idx_reg + IDX_W'(1);
            end
            ST_DEL_DRAIN:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_last;
            end
            ST_LIN:
            begin
                if (chk_hit)
                begin
                    res_index_next = pend_addr_reg;
                end
                else if (pend_reg && (CNT_W'(pend_addr_reg) == cnt_last))
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end
            ST_BIN_RD:
            begin
                mem_raddr = mid_calc;
                mid_next  = mid_calc;
                if (bin_empty)
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
            end
            ST_BIN_CMP:
            begin
                if (rdata_reg == val_reg)
                begin
                    res_index_next = mid_reg;
                end
                else if (probe_less)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi1_next = CNT_W'(mid_reg);
                end
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    found_index_next = res_index_reg;
                    entry_count_next = cnt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= table_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        idx_reg         <= idx_next;
        pend_addr_reg   <= pend_addr_next;
        lo_reg          <= lo_next;
        hi1_reg         <= hi1_next;
        mid_reg         <= mid_next;
        res_status_reg  <= res_status_next;
        res_index_reg   <= res_index_next;
        status_reg      <= status_next;
        found_index_reg <= found_index_next;
        entry_count_reg <= entry_count_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign found_index = found_index_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire
